[sv/sps_pkg.sv]
// package for the stepper position servo
// beat types, event kinds, register map, coil table and reset values; no dependencies
package sps_pkg;

  localparam int unsigned AvgDepthDefault = 32;

  localparam logic [7:0] UndervoltReset   = 8'd135;
  localparam logic [7:0] OvercurrentReset = 8'd30;
  localparam logic [7:0] DeadbandReset    = 8'd5;
  localparam logic [7:0] LowLimitReset    = 8'd5;
  localparam logic [7:0] HighLimitReset   = 8'd100;

  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    KIND_POSITION = 3'd0,
    KIND_VOLTAGE  = 3'd1,
    KIND_CURRENT  = 3'd2,
    KIND_TICK     = 3'd3,
    KIND_HOST     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    REG_UNDERVOLT   = 3'd0,
    REG_OVERCURRENT = 3'd1,
    REG_DEADBAND    = 3'd2,
    REG_LOW_LIMIT   = 3'd3,
    REG_HIGH_LIMIT  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] sample;
    logic [7:0] target_position;
    logic [2:0] host_status;
  } sps_in_t;

  typedef struct packed {
    logic [3:0] coil_pattern;
    logic [7:0] position_average;
    logic       run_flag;
    logic       undervolt_flag;
    logic       overcurrent_flag;
  } sps_out_t;

  localparam logic [3:0] CoilTable [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

endpackage

[sv/sps_cell.sv]
// one slot of the position sample shift line
// holds a sample and hands it to the next slot on every shift; no dependencies
module sps_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] data_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

[sv/sps_ring.sv]
// running average over a chain of sample cells
// uses sps_cell; sum update and constant reciprocal divide into a registered average
module sps_ring #(
  parameter int unsigned AVG_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] sample_i,
  output logic [7:0] average_o
);

  localparam int unsigned Log2D = $clog2(AVG_DEPTH);
  localparam int unsigned SumW  = 8 + Log2D;
  localparam int unsigned Shift = SumW + Log2D;
  localparam logic [63:0] RecipFull = ((64'd1 << Shift) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam logic [SumW:0] Recip = RecipFull[SumW:0];

  logic [7:0] tap [AVG_DEPTH+1];
  logic [SumW-1:0] sum_q, sum_d;
  logic [7:0] avg_q, avg_d;
  logic [2*SumW:0] prod;

  assign tap[0] = sample_i;

  for (genvar i = 0; i < AVG_DEPTH; i++) begin : g_cell
    sps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_i),
      .data_i (tap[i]),
      .data_o (tap[i+1])
    );
  end

  always_comb begin
    sum_d = sum_q;
    if (shift_i) begin
      sum_d = sum_q - {{(SumW-8){1'b0}}, tap[AVG_DEPTH]} + {{(SumW-8){1'b0}}, sample_i};
    end
    prod  = {{(SumW+1){1'b0}}, sum_d} * {{(SumW){1'b0}}, Recip};
    avg_d = prod[Shift +: 8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      avg_q <= '0;
    end else begin
      sum_q <= sum_d;
      avg_q <= avg_d;
    end
  end

  assign average_o = avg_q;

endmodule

[sv/stepper_position_servo.sv]
// closed-loop stepper position servo, top level
// uses sps_pkg and sps_ring; event decode, fault latches, coil stepping, apb registers
//
// input beats carry one event: position, voltage or current sample, a stepping
// tick, or a host write of target and status bits. every accepted beat gives
// exactly one output beat with the coil pattern, position average and flags
// as they stand after that event.
// the output beat is registered in the cycle after its input; unless the output
// stalls, one beat per cycle is taken back to back. position samples shift
// through AVG_DEPTH cells; a constant reciprocal divides their sum into the average.
// the output beat sits in the state registers themselves: while out_stall_i
// holds a waiting beat, in_stall_o is high and everything holds still.
// reset clears the sample line, sum, phase, target, status and coil at once
// and loads the register defaults; no beat is pending after reset.
// registers are written over apb at byte address 4*i, pready is always high.
module stepper_position_servo
  import sps_pkg::*;
#(
  parameter int unsigned AVG_DEPTH = AvgDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sps_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sps_out_t            out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0] uv_thr_q, oc_thr_q, deadband_q, low_lim_q, high_lim_q;
  logic [2:0] status_q, status_d;
  logic [2:0] phase_q, phase_d;
  logic [3:0] coil_q, coil_d;
  logic [7:0] target_q, target_d;
  logic       out_valid_q;
  logic       accept;
  logic       cfg_wr;
  logic [7:0] avg;
  logic [2:0] phase_back;
  logic [8:0] a_ext, t_ext;
  reg_idx_e   cfg_idx;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  sps_ring #(
    .AVG_DEPTH(AVG_DEPTH)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (accept && in_data_i.kind == KIND_POSITION),
    .sample_i (in_data_i.sample),
    .average_o(avg)
  );

  assign a_ext      = {1'b0, avg};
  assign t_ext      = {1'b0, target_q};
  assign phase_back = phase_q - 3'd1;

  always_comb begin
    status_d = status_q;
    phase_d  = phase_q;
    coil_d   = coil_q;
    target_d = target_q;
    if (accept) begin
      unique case (in_data_i.kind)
        KIND_VOLTAGE: begin
          if (in_data_i.sample < uv_thr_q) status_d[1] = 1'b1;
        end
        KIND_CURRENT: begin
          if (in_data_i.sample > oc_thr_q) status_d[0] = 1'b1;
        end
        KIND_TICK: begin
          if (status_q[2] && !status_q[0]) begin
            if (avg > target_q) begin
              if (avg < low_lim_q) status_d[2] = 1'b0;
              coil_d  = CoilTable[phase_q];
              phase_d = phase_q + 3'd1;
            end
            if (avg < target_q) begin
              if (avg > high_lim_q) status_d[2] = 1'b0;
              phase_d = phase_back;
              coil_d  = CoilTable[phase_back];
            end
            if ((a_ext + {1'b0, deadband_q} > t_ext) &&
                (a_ext < t_ext + {1'b0, deadband_q})) begin
              status_d[2] = 1'b0;
            end
          end
        end
        KIND_HOST: begin
          target_d = in_data_i.target_position;
          status_d = in_data_i.host_status;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= '0;
      phase_q     <= '0;
      coil_q      <= '0;
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      status_q <= status_d;
      phase_q  <= phase_d;
      coil_q   <= coil_d;
      target_q <= target_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o                   = out_valid_q;
  assign out_data_o.coil_pattern       = coil_q;
  assign out_data_o.position_average   = avg;
  assign out_data_o.run_flag           = status_q[2];
  assign out_data_o.undervolt_flag     = status_q[1];
  assign out_data_o.overcurrent_flag   = status_q[0];

  // apb register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uv_thr_q   <= UndervoltReset;
      oc_thr_q   <= OvercurrentReset;
      deadband_q <= DeadbandReset;
      low_lim_q  <= LowLimitReset;
      high_lim_q <= HighLimitReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_UNDERVOLT:   uv_thr_q   <= pwdata[7:0];
        REG_OVERCURRENT: oc_thr_q   <= pwdata[7:0];
        REG_DEADBAND:    deadband_q <= pwdata[7:0];
        REG_LOW_LIMIT:   low_lim_q  <= pwdata[7:0];
        REG_HIGH_LIMIT:  high_lim_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_UNDERVOLT:   prdata = {24'd0, uv_thr_q};
      REG_OVERCURRENT: prdata = {24'd0, oc_thr_q};
      REG_DEADBAND:    prdata = {24'd0, deadband_q};
      REG_LOW_LIMIT:   prdata = {24'd0, low_lim_q};
      REG_HIGH_LIMIT:  prdata = {24'd0, high_lim_q};
      default:         prdata = '0;
    endcase
  end

endmodule

[sv/sps_checker.sv]
// port-level checks for the stepper position servo
// uses sps_pkg; bound to stepper_position_servo below
module sps_checker
  import sps_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sps_out_t out_data_o
);

  a_beat_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted input beat gave no output beat");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |-> !in_stall_o)
    else $error("input stalled with room at the output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output beat changed");

  a_coil_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($onehot0(out_data_o.coil_pattern) ||
                     out_data_o.coil_pattern == 4'h3 || out_data_o.coil_pattern == 4'h6 ||
                     out_data_o.coil_pattern == 4'hC || out_data_o.coil_pattern == 4'h9))
    else $error("coil pattern outside the half-step set");

endmodule

bind stepper_position_servo sps_checker u_sps_checker (.*);
